FILE: hw/rtl/rplt_pkg.sv
// Shared types, constants and register map of the relay pulse and lockout timer.
package rplt_pkg;

	localparam int NUM_CHANNELS = 4;
	localparam int CH_IDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int MAX_RESULTS  = 4;
	localparam int RES_IDX_W    = $clog2(MAX_RESULTS);
	localparam int RES_CNT_W    = $clog2(MAX_RESULTS + 1);
	localparam int TIMER_W      = 24;
	localparam int ELAPSED_W    = 16;
	localparam int CMD_W        = 2;
	localparam int OUT_CH_W     = 2;
	localparam int ADDR_W       = 5;
	localparam int DATA_W       = 32;
	localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

	// Command codes of an input transaction
	localparam logic [CMD_W-1:0] CMD_SET     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TICK    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_OFF_ALL = 2'd2;

	// Register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_RELAY_EN  = 3'd0;
	localparam logic [2:0] REG_PULSE_EN  = 3'd1;
	localparam logic [2:0] REG_PULSE_MS  = 3'd2;
	localparam logic [2:0] REG_LOCK_EN   = 3'd3;
	localparam logic [2:0] REG_LOCK_MS   = 3'd4;

	typedef struct packed {
		logic               relay_en;
		logic               pulse_en;
		logic [TIMER_W-1:0] pulse_time;
		logic               lock_en;
		logic [TIMER_W-1:0] lock_time;
	} cfg_t;

	typedef struct packed {
		logic               wanted;
		logic               applied;
		logic [TIMER_W-1:0] on_timer;
		logic [TIMER_W-1:0] rec_timer;
	} chan_state_t;

	typedef struct packed {
		logic empty;
		logic last;
	} res_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN
	} state_t;

endpackage

FILE: hw/rtl/rplt_cfg.sv
// APB register file holding the timer configuration.
module rplt_cfg (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [rplt_pkg::ADDR_W-1:0] paddr,
	input  logic [rplt_pkg::DATA_W-1:0] pwdata,
	output logic [rplt_pkg::DATA_W-1:0] prdata,
	output logic                    pready,
	output rplt_pkg::cfg_t          cfg,
	output logic                    rec_preset
);
	import rplt_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg     = cfg_q;

	// Writing the lockout time presets every recovery timer
	assign rec_preset = wr_en && (reg_idx == REG_LOCK_MS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_RELAY_EN: cfg_q.relay_en   <= pwdata[0];
				REG_PULSE_EN: cfg_q.pulse_en   <= pwdata[0];
				REG_PULSE_MS: cfg_q.pulse_time <= pwdata[TIMER_W-1:0];
				REG_LOCK_EN:  cfg_q.lock_en    <= pwdata[0];
				REG_LOCK_MS:  cfg_q.lock_time  <= pwdata[TIMER_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_RELAY_EN: prdata = DATA_W'(cfg_q.relay_en);
			REG_PULSE_EN: prdata = DATA_W'(cfg_q.pulse_en);
			REG_PULSE_MS: prdata = DATA_W'(cfg_q.pulse_time);
			REG_LOCK_EN:  prdata = DATA_W'(cfg_q.lock_en);
			REG_LOCK_MS:  prdata = DATA_W'(cfg_q.lock_time);
			default:      prdata = '0;
		endcase
	end

endmodule

FILE: hw/rtl/rplt_step_unit.sv
// Shared per-channel update unit: one saturating timer add and one limit compare.
module rplt_step_unit (
	input  rplt_pkg::cfg_t                    cfg,
	input  logic [rplt_pkg::ELAPSED_W-1:0]    elapsed,
	input  rplt_pkg::chan_state_t             cur,
	output rplt_pkg::chan_state_t             nxt,
	output logic                              change
);
	import rplt_pkg::*;

	logic [TIMER_W-1:0] tval;
	logic [TIMER_W-1:0] limit;
	logic [TIMER_W:0]   sum;
	logic [TIMER_W-1:0] sat;
	logic               below;

	// On channels run the on-timer against the pulse time, off channels the
	// recovery timer against the lockout time
	assign tval  = cur.applied ? cur.on_timer : cur.rec_timer;
	assign limit = cur.applied ? cfg.pulse_time : cfg.lock_time;
	assign below = tval < limit;
	assign sum   = {1'b0, tval} + (TIMER_W+1)'(elapsed);
	assign sat   = sum[TIMER_W] ? TIMER_MAX : sum[TIMER_W-1:0];

	always_comb begin
		nxt = cur;
		if (cur.applied && cfg.pulse_en) begin
			if (below) begin
				nxt.on_timer = sat;
				nxt.wanted   = 1'b1;
			end else begin
				nxt.wanted = 1'b0;
				if (cfg.lock_en) begin
					nxt.rec_timer = '0;
				end
			end
		end
		if (!cur.applied && cfg.lock_en && below) begin
			nxt.rec_timer = sat;
			nxt.wanted    = 1'b0;
		end
		change = nxt.wanted != cur.applied;
		if (change) begin
			nxt.applied   = nxt.wanted;
			nxt.on_timer  = '0;
			nxt.rec_timer = '0;
		end
	end

endmodule

FILE: hw/rtl/rplt_res_buf.sv
// Result buffer: collects the messages of one walk, then drains them in order.
module rplt_res_buf (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              clr,
	input  logic                              push,
	input  logic [rplt_pkg::OUT_CH_W-1:0]     push_ch,
	input  logic                              push_lvl,
	input  logic                              pop,
	output logic [rplt_pkg::OUT_CH_W-1:0]     head_ch,
	output logic                              head_lvl,
	output rplt_pkg::res_stat_t               stat
);
	import rplt_pkg::*;

	logic [OUT_CH_W-1:0]  ch_q  [MAX_RESULTS];
	logic                 lvl_q [MAX_RESULTS];
	logic [RES_CNT_W-1:0] cnt_q;
	logic [RES_CNT_W-1:0] rd_q;
	logic                 full;

	assign full = cnt_q == RES_CNT_W'(MAX_RESULTS);

	// Drop pushes past the result limit
	always_ff @(posedge clk) begin
		if (push && !full) begin
			ch_q[cnt_q[RES_IDX_W-1:0]]  <= push_ch;
			lvl_q[cnt_q[RES_IDX_W-1:0]] <= push_lvl;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= '0;
		end else if (clr) begin
			cnt_q <= '0;
			rd_q  <= '0;
		end else begin
			if (push && !full) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
		end
	end

	assign head_ch    = ch_q[rd_q[RES_IDX_W-1:0]];
	assign head_lvl   = lvl_q[rd_q[RES_IDX_W-1:0]];
	assign stat.empty = cnt_q == '0;
	assign stat.last  = (rd_q + 1'b1) == cnt_q;

endmodule

FILE: hw/rtl/relay_pulse_lockout_timer.sv
// Relay pulse and lockout timer top level: sequencer, channel state and ports.
// Set-level transaction: accepted in idle and stored as the wanted level, no result.
// Tick and off-all: walk every channel through the shared step unit (one channel
// per cycle), then drain the results, held while result_ready is low; not ready
// meanwhile.
// Reset (arst_n low, asynchronous): registers, levels and timers clear to zero.
module relay_pulse_lockout_timer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rplt_pkg::ADDR_W-1:0]         paddr,
	input  logic [rplt_pkg::DATA_W-1:0]         pwdata,
	output logic [rplt_pkg::DATA_W-1:0]         prdata,
	output logic                                pready,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  logic [rplt_pkg::CMD_W-1:0]          cmd,
	input  logic [1:0]                          channel,
	input  logic                                level,
	input  logic [rplt_pkg::ELAPSED_W-1:0]      elapsed_ms,
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic [rplt_pkg::OUT_CH_W-1:0]       out_channel,
	output logic                                out_level,
	output logic [2:0]                          relay_code,
	output logic                                last_of_run
);
	import rplt_pkg::*;

	cfg_t                 cfg;
	logic                 rec_preset;
	state_t               state_q;
	state_t               state_nxt;
	logic                 accept;
	logic                 start_walk;
	logic                 walk_en;
	logic                 walk_last;
	logic                 pop;
	logic                 push;
	logic                 push_lvl;
	logic                 tick_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [CH_IDX_W-1:0]  idx_q;
	logic                 wanted_q  [NUM_CHANNELS];
	logic                 applied_q [NUM_CHANNELS];
	logic [TIMER_W-1:0]   on_q      [NUM_CHANNELS];
	logic [TIMER_W-1:0]   rec_q     [NUM_CHANNELS];
	chan_state_t          cur;
	chan_state_t          nxt;
	logic                 change;
	res_stat_t            stat;

	rplt_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.cfg        (cfg),
		.rec_preset (rec_preset)
	);

	assign accept     = item_valid && item_ready;
	assign start_walk = accept && cfg.relay_en && (cmd == CMD_TICK || cmd == CMD_OFF_ALL);
	assign walk_last  = idx_q == CH_IDX_W'(NUM_CHANNELS - 1);
	assign pop        = result_valid && result_ready;

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start_walk) begin
					state_nxt = ST_WALK;
				end
			end
			ST_WALK: begin
				if (walk_last) begin
					state_nxt = (!stat.empty || push) ? ST_DRAIN : ST_IDLE;
				end
			end
			ST_DRAIN: begin
				if (pop && stat.last) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		item_ready   = 1'b0;
		result_valid = 1'b0;
		walk_en      = 1'b0;
		unique case (state_q)
			ST_IDLE:  item_ready   = 1'b1;
			ST_WALK:  walk_en      = 1'b1;
			ST_DRAIN: result_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			tick_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (start_walk) begin
				idx_q  <= '0;
				tick_q <= cmd == CMD_TICK;
			end else if (walk_en && !walk_last) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_walk) begin
			elapsed_q <= elapsed_ms;
		end
	end

	assign cur.wanted    = wanted_q[idx_q];
	assign cur.applied   = applied_q[idx_q];
	assign cur.on_timer  = on_q[idx_q];
	assign cur.rec_timer = rec_q[idx_q];

	rplt_step_unit u_step (
		.cfg     (cfg),
		.elapsed (elapsed_q),
		.cur     (cur),
		.nxt     (nxt),
		.change  (change)
	);

	// Channel state: level requests on accept, updates of the walked channel, presets
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				wanted_q[i]  <= 1'b0;
				applied_q[i] <= 1'b0;
				on_q[i]      <= '0;
				rec_q[i]     <= '0;
			end
		end else begin
			if (rec_preset) begin
				for (int i = 0; i < NUM_CHANNELS; i++) begin
					rec_q[i] <= pwdata[TIMER_W-1:0];
				end
			end
			if (accept && cfg.relay_en && cmd == CMD_SET &&
			    32'(channel) < NUM_CHANNELS) begin
				wanted_q[CH_IDX_W'(channel)] <= level;
			end
			if (walk_en && tick_q) begin
				wanted_q[idx_q]  <= nxt.wanted;
				applied_q[idx_q] <= nxt.applied;
				on_q[idx_q]      <= nxt.on_timer;
				rec_q[idx_q]     <= nxt.rec_timer;
			end
		end
	end

	// Off-all pushes an off message for every walked channel; the buffer caps the count
	assign push     = walk_en && (tick_q ? change : 1'b1);
	assign push_lvl = tick_q ? nxt.applied : 1'b0;

	rplt_res_buf u_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (start_walk),
		.push     (push),
		.push_ch  (OUT_CH_W'(idx_q)),
		.push_lvl (push_lvl),
		.pop      (pop),
		.head_ch  (out_channel),
		.head_lvl (out_level),
		.stat     (stat)
	);

	assign relay_code  = {out_channel, ~out_level};
	assign last_of_run = stat.last;

endmodule

FILE: hw/rtl/rplt_checker.sv
// Port-level checker for the relay pulse and lockout timer, bound to the top level.
module rplt_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            item_ready,
	input logic                            result_valid,
	input logic                            result_ready,
	input logic [rplt_pkg::OUT_CH_W-1:0]   out_channel,
	input logic                            out_level,
	input logic [2:0]                      relay_code,
	input logic                            last_of_run
);

	// Never take a new transaction while results are pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(item_ready && result_valid))
		else $error("input accepted while results pending");

	// Drop result_valid after the final result of a run
	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready && last_of_run |=> !result_valid)
		else $error("results continue after last_of_run");

	// Code follows channel and level
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> relay_code == {out_channel, ~out_level})
		else $error("relay_code mismatch");

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(out_channel) &&
			$stable(out_level) && $stable(last_of_run))
		else $error("stalled result changed");

endmodule

bind relay_pulse_lockout_timer rplt_checker u_rplt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_ready   (item_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.out_channel  (out_channel),
	.out_level    (out_level),
	.relay_code   (relay_code),
	.last_of_run  (last_of_run)
);
